### hw/rtl/mmtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtm_pkg
// Shared types and constants for the matrix multiply engine with transpose
// modes: item kinds, register indexes, sequencer states and the tag that
// travels with each multiply-accumulate through the datapath.
// ----------------------------------------------------------------------------
package mmtm_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    // Eight products of 64 bits each fit in 67 bits; one spare bit.
    localparam int ACC_W  = PROD_W + 4;
    localparam int DIM_W  = 4;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 3;

    localparam logic [1:0] KIND_WR_A = 2'd0;
    localparam logic [1:0] KIND_WR_B = 2'd1;
    localparam logic [1:0] KIND_CALC = 2'd2;

    localparam logic [CFG_W-1:0] CFG_ROWS    = 3'd0;
    localparam logic [CFG_W-1:0] CFG_INNER   = 3'd1;
    localparam logic [CFG_W-1:0] CFG_COLS    = 3'd2;
    localparam logic [CFG_W-1:0] CFG_TRANS_A = 3'd3;
    localparam logic [CFG_W-1:0] CFG_TRANS_B = 3'd4;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             first_k;
        logic             last_k;
        logic             last_j;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // A dimension of zero acts as one, anything above the limit as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = 4'd1;
        end else if (v > lim) begin
            res = lim;
        end
        return res;
    endfunction

endpackage

### hw/rtl/mmtm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtm_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mmtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mmtm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtm_seq
// Configuration registers and the row sequencer: routes element writes to
// the two stores and walks the column and inner indexes of a compute
// transaction, issuing one read pair per cycle.
// ----------------------------------------------------------------------------
module mmtm_seq import mmtm_pkg::*; #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_kind,
    input  logic [IDX_W-1:0] i_row,
    input  logic [IDX_W-1:0] i_col,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    input  logic             i_row_done,
    output logic             o_busy,
    output logic             o_we_a,
    output logic             o_we_b,
    output logic [AW-1:0]    o_waddr,
    output logic [AW-1:0]    o_raddr_a,
    output logic [AW-1:0]    o_raddr_b,
    output t_tag             o_tag
);

    localparam int DIM_LIM = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam logic [DIM_W-1:0] DIM_LIM_V = DIM_W'(DIM_LIM);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_rows, r_inner, r_cols;
    logic             r_trans_a, r_trans_b;
    t_tag             r_tag;
    t_tag             w_issue;
    logic [DIM_W-1:0] w_nr, w_nk, w_nc;
    logic             w_wr_ok;
    logic [IDX_W-1:0] w_a_row, w_a_col, w_b_row, w_b_col;

    assign w_nr = clamp_dim(r_rows, DIM_LIM_V);
    assign w_nk = clamp_dim(r_inner, DIM_LIM_V);
    assign w_nc = clamp_dim(r_cols, DIM_LIM_V);

    assign w_wr_ok = ({1'b0, i_row} < DIM_LIM_V) && ({1'b0, i_col} < DIM_LIM_V);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= DIM_RESET;
            r_inner   <= DIM_RESET;
            r_cols    <= DIM_RESET;
            r_trans_a <= 1'b0;
            r_trans_b <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS:    r_rows    <= i_cfg_data;
                CFG_INNER:   r_inner   <= i_cfg_data;
                CFG_COLS:    r_cols    <= i_cfg_data;
                CFG_TRANS_A: r_trans_a <= i_cfg_data[0];
                CFG_TRANS_B: r_trans_b <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tag.valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tag.valid <= w_issue.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j           <= n_j;
        r_k           <= n_k;
        r_row         <= n_row;
        r_tag.first_k <= w_issue.first_k;
        r_tag.last_k  <= w_issue.last_k;
        r_tag.last_j  <= w_issue.last_j;
        r_tag.row     <= w_issue.row;
        r_tag.col     <= w_issue.col;
    end

    always_comb begin
        w_issue.valid   = (r_state == ST_RUN);
        w_issue.first_k = (r_k == '0);
        w_issue.last_k  = ({1'b0, r_k} == w_nk - 4'd1);
        w_issue.last_j  = ({1'b0, r_j} == w_nc - 4'd1);
        w_issue.row     = r_row;
        w_issue.col     = r_j;
    end

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_k     = r_k;
        n_row   = r_row;
        o_we_a  = 1'b0;
        o_we_b  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_we_a = (i_kind == KIND_WR_A) && w_wr_ok;
                    o_we_b = (i_kind == KIND_WR_B) && w_wr_ok;
                    if ((i_kind == KIND_CALC) && ({1'b0, i_row} < w_nr)) begin
                        n_state = ST_RUN;
                        n_row   = i_row;
                        n_j     = '0;
                        n_k     = '0;
                    end
                end
            end
            ST_RUN: begin
                if (w_issue.last_k) begin
                    n_k = '0;
                    if (w_issue.last_j) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_j = r_j + 3'd1;
                    end
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_DRAIN: begin
                if (i_row_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // op(A)[i][k] and op(B)[k][j] select stored row and column by the modes.
    assign w_a_row = r_trans_a ? r_k : r_row;
    assign w_a_col = r_trans_a ? r_row : r_k;
    assign w_b_row = r_trans_b ? r_j : r_k;
    assign w_b_col = r_trans_b ? r_k : r_j;

    assign o_raddr_a = AW'(32'(w_a_row) * 32'(MAX_DIM) + 32'(w_a_col));
    assign o_raddr_b = AW'(32'(w_b_row) * 32'(MAX_DIM) + 32'(w_b_col));
    assign o_waddr   = AW'(32'(i_row) * 32'(MAX_DIM) + 32'(i_col));

    assign o_busy = (r_state != ST_IDLE);
    assign o_tag  = r_tag;

endmodule

### hw/rtl/mmtm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtm_mac
// Multiply-accumulate datapath: registered 32x32 product, full-width
// accumulator, then arithmetic shift and saturation into the result register.
// ----------------------------------------------------------------------------
module mmtm_mac import mmtm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tag                     i_tag,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_strobe,
    output logic [IDX_W-1:0]         o_result_row,
    output logic [IDX_W-1:0]         o_result_col,
    output logic signed [DATA_W-1:0] o_product_value,
    output logic                     o_last
);

    t_tag                     r_ptag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic                     r_done_last;
    logic [IDX_W-1:0]         r_done_row, r_done_col;
    logic                     r_out_strobe;
    logic                     r_out_last;
    logic [IDX_W-1:0]         r_out_row, r_out_col;
    logic signed [DATA_W-1:0] r_out_value;
    logic signed [ACC_W-1:0]  w_shift;
    logic                     w_fits;
    logic signed [DATA_W-1:0] w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptag.valid <= 1'b0;
            r_done       <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_ptag.valid <= i_tag.valid;
            r_done       <= r_ptag.valid && r_ptag.last_k;
            r_out_strobe <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod         <= i_a * i_b;
        r_ptag.first_k <= i_tag.first_k;
        r_ptag.last_k  <= i_tag.last_k;
        r_ptag.last_j  <= i_tag.last_j;
        r_ptag.row     <= i_tag.row;
        r_ptag.col     <= i_tag.col;
        if (r_ptag.valid) begin
            r_acc <= (r_ptag.first_k ? '0 : r_acc)
                     + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        r_done_last <= r_ptag.last_j;
        r_done_row  <= r_ptag.row;
        r_done_col  <= r_ptag.col;
        r_out_last  <= r_done_last;
        r_out_row   <= r_done_row;
        r_out_col   <= r_done_col;
        r_out_value <= w_sat;
    end

    // The shift rounds toward minus infinity; the value fits when every bit
    // above the result's sign bit repeats it.
    assign w_shift = r_acc >>> FRAC_BITS;
    assign w_fits  = (&w_shift[ACC_W-1:DATA_W-1]) || !(|w_shift[ACC_W-1:DATA_W-1]);
    assign w_sat   = w_fits ? w_shift[DATA_W-1:0]
                   : (w_shift[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}});

    assign o_strobe        = r_out_strobe;
    assign o_last          = r_out_last;
    assign o_result_row    = r_out_row;
    assign o_result_col    = r_out_col;
    assign o_product_value = r_out_value;

endmodule

### hw/rtl/matrix_multiply_transpose_modes_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_transpose_modes_core
// Dense matrix product C = op(A) * op(B) in signed Q16.16 with selectable
// transposes of either operand.
// ----------------------------------------------------------------------------
// A write transaction stores one element of A or B and leaves busy low, so
// writes can be issued back to back. A compute transaction for a row with
// cols_out columns and inner dimension inner_len keeps busy high until its
// final column has been emitted: both stores have one read port, so the
// engine performs one multiply-accumulate per cycle, cols_out * inner_len in
// all, each passing the read, multiply, accumulate and saturate stages.
// Results appear in column order, each on the o_ ports for exactly one cycle
// while o_strobe is high, with o_last on the final column; the receiver must
// take every result in that cycle, since there is no way to stall the
// engine. A compute transaction for a row at or beyond rows_out produces
// nothing. Configuration may only be written while busy is low.
// ----------------------------------------------------------------------------
module matrix_multiply_transpose_modes_core import mmtm_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_kind,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_idx,
    input  logic [DIM_W-1:0]         i_cfg_data,
    output logic                     o_strobe,
    output logic [IDX_W-1:0]         o_result_row,
    output logic [IDX_W-1:0]         o_result_col,
    output logic signed [DATA_W-1:0] o_product_value,
    output logic                     o_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              w_we_a, w_we_b;
    logic [ADDR_W-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic [DATA_W-1:0] w_rdata_a, w_rdata_b;
    t_tag              w_tag;
    logic              w_row_done;

    assign w_row_done = o_strobe && o_last;

    mmtm_seq #(
        .MAX_DIM (MAX_DIM),
        .AW      (ADDR_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_kind     (i_kind),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_row_done (w_row_done),
        .o_busy     (busy),
        .o_we_a     (w_we_a),
        .o_we_b     (w_we_b),
        .o_waddr    (w_waddr),
        .o_raddr_a  (w_raddr_a),
        .o_raddr_b  (w_raddr_b),
        .o_tag      (w_tag)
    );

    mmtm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    mmtm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    mmtm_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tag           (w_tag),
        .i_a             (w_rdata_a),
        .i_b             (w_rdata_b),
        .o_strobe        (o_strobe),
        .o_result_row    (o_result_row),
        .o_result_col    (o_result_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

    // Results only come out of an accepted compute transaction.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while engine idle");

    // No result may come straight after the final column of a row.
    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result after final column");

    // A write never occupies the engine.
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_WR_A || i_kind == KIND_WR_B)) |=> !busy)
        else $error("write transaction raised busy");

    // Back-to-back results must be consecutive columns of the same row.
    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe)) |->
            (o_result_col == IDX_W'($past(o_result_col) + 3'd1)
             && o_result_row == $past(o_result_row)))
        else $error("results out of column order");

endmodule

### verif/mmtm_product_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtm_product_checker
// Watches the command, configuration and result ports of the matrix product
// engine, keeps its own copy of both operand stores and the dimension and
// transpose registers, works out every product row that an accepted compute
// transaction should emit, and compares each strobed element against the
// oldest one still owed.
// ----------------------------------------------------------------------------
module mmtm_product_checker import mmtm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [1:0]               i_kind,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic [DATA_W-1:0]        i_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_idx,
    input  logic [DIM_W-1:0]         i_cfg_data,
    input  logic                     i_strobe,
    input  logic [IDX_W-1:0]         i_result_row,
    input  logic [IDX_W-1:0]         i_result_col,
    input  logic [DATA_W-1:0]        i_product_value,
    input  logic                     i_last,
    output int                       o_errors,
    output int                       o_outstanding,
    output int                       o_results
);

    localparam int DIM_LIM = 8;
    localparam int FRAC    = 16;
    localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
    localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_product;

    logic signed [DATA_W-1:0] first_mat  [DIM_LIM][DIM_LIM];
    logic signed [DATA_W-1:0] second_mat [DIM_LIM][DIM_LIM];
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] inner_reg;
    logic [DIM_W-1:0] cols_reg;
    logic             trans_a;
    logic             trans_b;
    t_product         product_q[$];
    int               errors = 0;
    int               results = 0;

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_LIM) return DIM_LIM;
        return int'(v);
    endfunction

    // The exact sum is floored by the arithmetic shift, then clipped to 32 bits.
    function automatic logic [DATA_W-1:0] saturate_q16(input logic signed [71:0] sum);
        logic signed [71:0] scaled;
        scaled = sum >>> FRAC;
        if (scaled > SAT_MAX) return 32'h7FFF_FFFF;
        if (scaled < SAT_MIN) return 32'h8000_0000;
        return scaled[DATA_W-1:0];
    endfunction

    task automatic predict_row_products(input logic [IDX_W-1:0] row);
        int                       nr;
        int                       nk;
        int                       nc;
        logic signed [71:0]       sum;
        logic signed [DATA_W-1:0] a_el;
        logic signed [DATA_W-1:0] b_el;
        longint                   prod;
        t_product                 elem;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        if (int'(row) >= nr) return;
        for (int j = 0; j < nc; j++) begin
            sum = '0;
            for (int k = 0; k < nk; k++) begin
                a_el = trans_a ? first_mat[k][row] : first_mat[row][k];
                b_el = trans_b ? second_mat[j][k] : second_mat[k][j];
                prod = longint'(a_el) * longint'(b_el);
                sum  = sum + prod;
            end
            elem.row   = row;
            elem.col   = IDX_W'(j);
            elem.value = saturate_q16(sum);
            elem.last  = (j == nc - 1);
            product_q.push_back(elem);
        end
    endtask

    task automatic report(input string field, input logic [DATA_W-1:0] want,
                          input logic [DATA_W-1:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : monitor
        t_product want;
        if (!i_rst_n) begin
            foreach (first_mat[r, c]) begin
                first_mat[r][c]  = '0;
                second_mat[r][c] = '0;
            end
            rows_reg  = DIM_RESET;
            inner_reg = DIM_RESET;
            cols_reg  = DIM_RESET;
            trans_a   = 1'b0;
            trans_b   = 1'b0;
            product_q.delete();
        end else begin
            if (i_strobe) begin
                results++;
                if (product_q.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected product element, expected none, ",
                              "got row %0d col %0d value %h"},
                             $time, i_result_row, i_result_col, i_product_value);
                end else begin
                    want = product_q.pop_front();
                    if (i_result_row != want.row)
                        report("row", DATA_W'(want.row), DATA_W'(i_result_row));
                    if (i_result_col != want.col)
                        report("col", DATA_W'(want.col), DATA_W'(i_result_col));
                    if (i_product_value != want.value)
                        report("value", want.value, i_product_value);
                    if (i_last != want.last)
                        report("last", DATA_W'(want.last), DATA_W'(i_last));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS:    rows_reg  = i_cfg_data;
                    CFG_INNER:   inner_reg = i_cfg_data;
                    CFG_COLS:    cols_reg  = i_cfg_data;
                    CFG_TRANS_A: trans_a   = i_cfg_data[0];
                    CFG_TRANS_B: trans_b   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                case (i_kind)
                    KIND_WR_A: first_mat[i_row][i_col]  = i_value;
                    KIND_WR_B: second_mat[i_row][i_col] = i_value;
                    KIND_CALC: predict_row_products(i_row);
                    default: ;
                endcase
            end
        end
        o_errors      <= errors;
        o_outstanding <= product_q.size();
        o_results     <= results;
    end

endmodule

### verif/tb_matrix_multiply_transpose_modes_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_transpose_modes_core
// Drives element writes and row computes into the matrix product engine
// across a series of dimension and transpose settings, starting with
// saturation, rounding and out-of-range cases and moving on to random
// traffic. Every operand a compute will read is written first. Checking is
// done by the product checker instantiated beside the engine.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_transpose_modes_core;
    import mmtm_pkg::*;

    localparam logic [1:0]       KIND_NONE     = 2'd3;
    localparam logic [CFG_W-1:0] CFG_UNUSED    = 3'd7;
    localparam int               SETTLE_CYCLES = 80;
    localparam int               OP_BUDGET     = 180;
    localparam logic [DATA_W-1:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN        = 32'h8000_0000;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     start      = 1'b0;
    logic [1:0]               i_kind     = '0;
    logic [IDX_W-1:0]         i_row      = '0;
    logic [IDX_W-1:0]         i_col      = '0;
    logic signed [DATA_W-1:0] i_value    = '0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_W-1:0]         i_cfg_idx  = '0;
    logic [DIM_W-1:0]         i_cfg_data = '0;
    logic                     busy;
    logic                     o_strobe;
    logic [IDX_W-1:0]         o_result_row;
    logic [IDX_W-1:0]         o_result_col;
    logic signed [DATA_W-1:0] o_product_value;
    logic                     o_last;

    int          errors;
    int          outstanding;
    int          results;
    int          dim_rows = 8;
    int          dim_inner = 8;
    int          dim_cols = 8;
    logic        tr_a = 1'b0;
    logic        tr_b = 1'b0;
    logic [63:0] a_written = '0;
    logic [63:0] b_written = '0;
    int          ops_sent = 0;
    int          calcs_sent = 0;
    int          phases = 0;
    bit          gaps_on = 1'b1;

    always #5 i_clk = ~i_clk;

    matrix_multiply_transpose_modes_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_value         (i_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_result_row    (o_result_row),
        .o_result_col    (o_result_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

    mmtm_product_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_kind          (i_kind),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_value         (i_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_strobe        (o_strobe),
        .i_result_row    (o_result_row),
        .i_result_col    (o_result_col),
        .i_product_value (o_product_value),
        .i_last          (o_last),
        .o_errors        (errors),
        .o_outstanding   (outstanding),
        .o_results       (results)
    );

    function automatic int fit_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > 8) return 8;
        return int'(v);
    endfunction

    // Mostly moderate Q16.16 values so that sums do not always saturate.
    function automatic logic [DATA_W-1:0] rand_value();
        logic [DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return '1;
            4, 5: return r;
            default: return {{11{r[20]}}, r[20:0]};
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return DIM_W'($urandom_range(9, 15));
            2, 3, 4: return DIM_W'($urandom_range(5, 8));
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    // All driving tasks start and end at a falling edge. start is left high
    // after a transaction so that the next one can follow back to back.
    task automatic send_op(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_kind  <= kind;
        i_row   <= row;
        i_col   <= col;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        ops_sent++;
    endtask

    task automatic write_elem(input logic [1:0] kind, input int row, input int col,
                              input logic [DATA_W-1:0] value);
        send_op(kind, IDX_W'(row), IDX_W'(col), value);
        if (kind == KIND_WR_A) a_written[row * 8 + col] = 1'b1;
        else b_written[row * 8 + col] = 1'b1;
    endtask

    // Writes any unwritten operand the row is going to read, then sends the compute.
    task automatic compute_row(input int row);
        int ar;
        int ac;
        int br;
        int bc;
        for (int k = 0; k < dim_inner; k++) begin
            ar = tr_a ? k : row;
            ac = tr_a ? row : k;
            if (!a_written[ar * 8 + ac]) write_elem(KIND_WR_A, ar, ac, rand_value());
            for (int j = 0; j < dim_cols; j++) begin
                br = tr_b ? j : k;
                bc = tr_b ? k : j;
                if (!b_written[br * 8 + bc]) write_elem(KIND_WR_B, br, bc, rand_value());
            end
        end
        send_op(KIND_CALC, IDX_W'(row), IDX_W'($urandom), $urandom);
        calcs_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_W-1:0] idx, input logic [DIM_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                              input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] ta,
                              input logic [DIM_W-1:0] tb);
        cfg_write(CFG_ROWS, rows);
        cfg_write(CFG_INNER, inner);
        cfg_write(CFG_COLS, cols);
        cfg_write(CFG_TRANS_A, ta);
        cfg_write(CFG_TRANS_B, tb);
        i_cfg_we  <= 1'b0;
        dim_rows  = fit_dim(rows);
        dim_inner = fit_dim(inner);
        dim_cols  = fit_dim(cols);
        tr_a      = ta[0];
        tr_b      = tb[0];
        phases++;
    endtask

    // Waits until every owed element has been checked and the engine is idle,
    // then pads a while before the registers are rewritten.
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0 || busy);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int pick;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Saturation both ways, floor rounding of a negative sum, rows past
        // rows_out, the unused kind and an unused register index.
        cfg_write(CFG_UNUSED, 4'hF);
        set_config(4'd3, 4'd2, 4'd2, 4'd0, 4'd0);
        write_elem(KIND_WR_A, 0, 0, Q_MAX);
        write_elem(KIND_WR_A, 0, 1, Q_MAX);
        write_elem(KIND_WR_B, 0, 0, Q_MAX);
        write_elem(KIND_WR_B, 1, 0, Q_MAX);
        write_elem(KIND_WR_B, 0, 1, Q_MIN);
        write_elem(KIND_WR_B, 1, 1, Q_MIN);
        compute_row(0);
        write_elem(KIND_WR_A, 1, 0, 32'hFFFF_FFFF);
        write_elem(KIND_WR_A, 1, 1, '0);
        compute_row(1);
        send_op(KIND_CALC, 3'd3, 3'd0, '0);
        send_op(KIND_CALC, 3'd7, 3'd7, '1);
        send_op(KIND_NONE, 3'd7, 3'd7, Q_MIN);
        write_elem(KIND_WR_A, 7, 7, Q_MIN);
        write_elem(KIND_WR_B, 7, 7, Q_MAX);
        compute_row(2);

        // Register values of zero and beyond the limits, with transposes.
        settle();
        set_config(4'd15, 4'd0, 4'd15, 4'd1, 4'd1);
        compute_row(7);
        settle();
        set_config(4'd0, 4'd15, 4'd0, 4'd0, 4'd1);
        compute_row(0);

        while (ops_sent < OP_BUDGET) begin
            settle();
            set_config(rand_dim(), rand_dim(), rand_dim(), DIM_W'($urandom),
                       DIM_W'($urandom));
            repeat ($urandom_range(6, 16)) begin
                if (ops_sent >= OP_BUDGET) break;
                gaps_on = (ops_sent < OP_BUDGET * 3 / 4);
                pick    = $urandom_range(0, 99);
                if (pick < 55) begin
                    compute_row($urandom_range(0, dim_rows - 1));
                end else if (pick < 78) begin
                    write_elem($urandom_range(0, 1) ? KIND_WR_B : KIND_WR_A,
                               $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
                end else if (pick < 90) begin
                    if (dim_rows < 8)
                        send_op(KIND_CALC, IDX_W'($urandom_range(dim_rows, 7)),
                                IDX_W'($urandom), $urandom);
                    else
                        compute_row(7);
                end else begin
                    send_op(KIND_NONE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
                end
            end
        end

        start <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Sent %0d transactions (%0d row computes) over %0d register settings.",
                 ops_sent, calcs_sent, phases);
        $display("Checked %0d product elements, %0d errors.", results, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Run did not complete in the allotted time.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mmtm_pkg.sv
hw/rtl/mmtm_ram.sv
hw/rtl/mmtm_seq.sv
hw/rtl/mmtm_mac.sv
hw/rtl/matrix_multiply_transpose_modes_core.sv
verif/mmtm_product_checker.sv
verif/tb_matrix_multiply_transpose_modes_core.sv
